[src/dhcp_crp_pkg.sv]
// Shared types and constants of the DHCP client reply parser.
package dhcp_crp_pkg;

	localparam int DNS_SLOTS_DEF       = 4;
	localparam int MAX_FRAME_BYTES_DEF = 2048;
	localparam int RESULT_CAP          = 4;
	localparam int RES_CNT_W           = 3;
	localparam int DNS_CNT_W           = 4;
	localparam int QUEUE_PTR_W         = 1;

	localparam logic [31:0] XID_RESET      = 32'h12345678;
	localparam logic [31:0] XID_STEP       = 32'h01020304;
	localparam logic [31:0] MAGIC_COOKIE   = 32'h63825363;
	localparam logic [31:0] MASK_DEFAULT   = 32'hFFFFFF00;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] PORT_SERVER    = 16'd67;
	localparam logic [15:0] PORT_CLIENT    = 16'd68;

	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_MASK   = 8'd1;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS    = 8'd6;
	localparam logic [7:0] OPT_MSG    = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;
	localparam logic [7:0] OPT_END    = 8'd255;

	localparam logic [31:0] MSG_OFFER = 32'd2;
	localparam logic [31:0] MSG_ACK   = 32'd5;

	typedef enum logic [2:0] {
		ACT_DROP     = 3'd0,
		ACT_DISCOVER = 3'd1,
		ACT_REQUEST  = 3'd2,
		ACT_LEASE    = 3'd3,
		ACT_MISMATCH = 3'd4,
		ACT_IGNORED  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_OFFER = 2'd1,
		PH_ACK   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		OM_CODE = 2'd0,
		OM_LEN  = 2'd1,
		OM_BODY = 2'd2,
		OM_DONE = 2'd3
	} opt_mode_t;

	typedef struct packed {
		logic [47:0] src_mac;
		logic [15:0] ether_kind;
		logic [7:0]  vihl;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] ulen;
		logic [31:0] xid;
		logic [31:0] yiaddr;
		logic [31:0] cookie;
	} hdr_t;

	typedef struct packed {
		opt_mode_t            mode;
		logic [7:0]           code;
		logic [7:0]           len;
		logic [7:0]           idx;
		logic [31:0]          word;
		logic [31:0]          first4;
		logic [DNS_CNT_W-1:0] pend;
	} opt_t;

	typedef struct packed {
		logic [31:0] msg;
		logic [31:0] server;
		logic [31:0] mask;
		logic [31:0] router;
	} vals_t;

	typedef struct packed {
		action_t                        action;
		logic [31:0]                    xid;
		logic [31:0]                    client;
		logic [31:0]                    server;
		logic [31:0]                    mask;
		logic [31:0]                    router;
		logic                           changed;
		logic [47:0]                    smac;
		logic                           smac_ok;
		logic [RESULT_CAP-1:0][31:0]    dns;
		logic [RES_CNT_W-1:0]           n;
	} rec_t;

endpackage

[src/dhcp_client_reply_parser.sv]
// Top level of the DHCP client reply parser.
// Input side is a push port: drive operation, data_byte and last_byte with push; a
// word is taken at a clock edge where push is high and full is low. A frame byte
// or a start command is taken every cycle while full is low.
// Result side is a queue: while empty is low the oldest result is on the result
// ports, and it is removed at an edge where pop is high.
// A start command or the last byte of a frame writes a record into the queue; an
// acknowledge with several DNS servers gives up to four results from it, one per
// cycle while pop is held.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes our own MAC
// address; cfg_ready is always high.
// Between the parser and the result side sits a two-entry record queue. When
// the receiver stalls, this queue fills and full rises, holding off the source.
// Asynchronous reset clears the session, sets the transaction id to its
// initial value and empties the record queue.
module dhcp_client_reply_parser #(
	parameter int DNS_SLOTS       = dhcp_crp_pkg::DNS_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = dhcp_crp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  action,
	output logic [31:0] transaction_id,
	output logic [31:0] client_addr,
	output logic [31:0] server_addr,
	output logic [31:0] net_mask,
	output logic [31:0] router_addr,
	output logic        addr_moved,
	output logic [47:0] server_mac,
	output logic        server_mac_ok,
	output logic [31:0] dns_server,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] cfg_data
);
	import dhcp_crp_pkg::*;

	logic item_acc, rec_valid, rd_en;
	rec_t rec, head;

	assign cfg_ready = 1'b1;
	assign item_acc  = push && !full;

	dhcp_crp_front #(
		.DNS_SLOTS      (DNS_SLOTS),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_acc (item_acc),
		.operation(operation),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rec_valid(rec_valid),
		.rec      (rec)
	);

	dhcp_crp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_valid),
		.wr_rec (rec),
		.q_full (full),
		.q_empty(empty),
		.rd_en  (rd_en),
		.rd_rec (head)
	);

	dhcp_crp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (empty),
		.head          (head),
		.pop           (pop),
		.rd_en         (rd_en),
		.action        (action),
		.transaction_id(transaction_id),
		.client_addr   (client_addr),
		.server_addr   (server_addr),
		.net_mask      (net_mask),
		.router_addr   (router_addr),
		.addr_moved    (addr_moved),
		.server_mac    (server_mac),
		.server_mac_ok (server_mac_ok),
		.dns_server    (dns_server),
		.last          (last)
	);

endmodule

[src/dhcp_crp_front.sv]
// Front part: frame byte parser, session state and per-word decision record.
module dhcp_crp_front #(
	parameter int DNS_SLOTS       = dhcp_crp_pkg::DNS_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = dhcp_crp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_acc,
	input  logic               operation,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               cfg_we,
	input  logic [47:0]        cfg_data,
	output logic               rec_valid,
	output dhcp_crp_pkg::rec_t rec
);
	import dhcp_crp_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IDX_W = (DNS_SLOTS > 1) ? $clog2(DNS_SLOTS) : 1;

	logic [47:0]      own_mac_q;
	phase_t           phase_q, phase_n;
	logic             active_q, active_n;
	logic [31:0]      cur_xid_q, cur_xid_n, prev_xid_q, prev_xid_n;
	logic [31:0]      offered_q, offered_n, sserver_q, sserver_n, iface_q, iface_n;
	logic [47:0]      smac_q, smac_n;
	logic             smac_ok_q, smac_ok_n;
	logic [POS_W-1:0] pos_q, pos_n;
	hdr_t             h_q, hn;
	opt_t             o_q, on;
	vals_t            v_q, vn;
	logic [DNS_CNT_W-1:0] cnt_q, cnt_n;
	logic [31:0]      dns_q [DNS_SLOTS];
	logic [31:0]      dns_n [DNS_SLOTS];

	logic             is_start, is_last, take;
	logic [3:0]       ihl, ihl_j;
	logic [17:0]      uoff, uoff_j, r18, ulen18, len18, b18;
	logic [POS_W-1:0] r;
	logic [31:0]      w;
	logic [DNS_CNT_W:0] slot;
	logic [7:0]       idx1;
	logic             bad, cur, prev, sane;
	phase_t           phase_eff;
	logic [31:0]      server;

	assign is_start = item_acc && operation;
	assign is_last  = item_acc && !operation && last_byte;
	assign take     = item_acc && !operation && (pos_q < POS_W'(MAX_FRAME_BYTES));

	always_comb begin
		hn    = h_q;
		on    = o_q;
		vn    = v_q;
		cnt_n = cnt_q;
		pos_n = pos_q;
		for (int j = 0; j < DNS_SLOTS; j++) begin
			dns_n[j] = dns_q[j];
		end
		ihl    = 4'd0;
		uoff   = 18'd0;
		r      = '0;
		r18    = 18'd0;
		ulen18 = 18'(h_q.ulen);
		b18    = 18'(data_byte);
		w      = {o_q.word[23:0], data_byte};
		slot   = (DNS_CNT_W + 1)'(cnt_q) + (DNS_CNT_W + 1)'(o_q.pend);
		idx1   = o_q.idx + 8'd1;
		if (take) begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q >= POS_W'(6) && pos_q < POS_W'(12)) begin
				hn.src_mac = {h_q.src_mac[39:0], data_byte};
			end
			if (pos_q == POS_W'(12) || pos_q == POS_W'(13)) begin
				hn.ether_kind = {h_q.ether_kind[7:0], data_byte};
			end
			if (pos_q == POS_W'(14)) begin
				hn.vihl = data_byte;
			end
			if (pos_q == POS_W'(23)) begin
				hn.proto = data_byte;
			end
			if (pos_q >= POS_W'(26) && pos_q < POS_W'(30)) begin
				hn.src_ip = {h_q.src_ip[23:0], data_byte};
			end
			ihl  = h_q.vihl[3:0];
			uoff = 18'd14 + 18'({ihl, 2'b00});
			if (pos_q >= POS_W'(15) && h_q.vihl[7:4] == 4'd4 && ihl >= 4'd5 &&
				18'(pos_q) >= uoff) begin
				r18 = 18'(pos_q) - uoff;
				r   = r18[POS_W-1:0];
				if (r < POS_W'(2)) begin
					hn.sport = {h_q.sport[7:0], data_byte};
				end else if (r < POS_W'(4)) begin
					hn.dport = {h_q.dport[7:0], data_byte};
				end else if (r < POS_W'(6)) begin
					hn.ulen = {h_q.ulen[7:0], data_byte};
				end else if (r >= POS_W'(12) && r < POS_W'(16)) begin
					hn.xid = {h_q.xid[23:0], data_byte};
				end else if (r >= POS_W'(24) && r < POS_W'(28)) begin
					hn.yiaddr = {h_q.yiaddr[23:0], data_byte};
				end else if (r >= POS_W'(244) && r < POS_W'(248)) begin
					hn.cookie = {h_q.cookie[23:0], data_byte};
				end else if (r >= POS_W'(248) && h_q.ulen >= 16'd248) begin
					case (o_q.mode)
						OM_CODE: begin
							if (r18 + 18'd1 >= ulen18 || data_byte == OPT_END) begin
								on.mode = OM_DONE;
							end else if (data_byte != OPT_PAD) begin
								on.code = data_byte;
								on.mode = OM_LEN;
							end
						end
						OM_LEN: begin
							if (r18 + 18'd1 + b18 > ulen18) begin
								on.mode = OM_DONE;
							end else begin
								on.len    = data_byte;
								on.idx    = 8'd0;
								on.word   = 32'd0;
								on.first4 = 32'd0;
								on.pend   = '0;
								on.mode   = (data_byte == 8'd0) ? OM_CODE : OM_BODY;
							end
						end
						OM_BODY: begin
							on.word = w;
							if (o_q.code == OPT_MSG && o_q.idx == 8'd0) begin
								on.first4 = 32'(data_byte);
							end
							if (o_q.code != OPT_MSG && o_q.idx == 8'd3) begin
								on.first4 = w;
							end
							if (o_q.code == OPT_DNS && o_q.idx[1:0] == 2'd3 && w != 32'd0 &&
								slot < (DNS_CNT_W + 1)'(DNS_SLOTS)) begin
								dns_n[slot[IDX_W-1:0]] = w;
								on.pend = o_q.pend + DNS_CNT_W'(1);
							end
							on.idx = idx1;
							if (idx1 >= o_q.len) begin
								if (o_q.code == OPT_MSG) begin
									vn.msg = on.first4;
								end else if (o_q.len >= 8'd4) begin
									if (o_q.code == OPT_SERVER) begin
										vn.server = on.first4;
									end else if (o_q.code == OPT_MASK) begin
										vn.mask = on.first4;
									end else if (o_q.code == OPT_ROUTER) begin
										vn.router = on.first4;
									end
								end
								if (o_q.code == OPT_DNS) begin
									cnt_n = cnt_q + on.pend;
								end
								on.mode = OM_CODE;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_comb begin
		phase_n   = phase_q;
		active_n  = active_q;
		cur_xid_n = cur_xid_q;
		prev_xid_n = prev_xid_q;
		offered_n = offered_q;
		sserver_n = sserver_q;
		smac_n    = smac_q;
		smac_ok_n = smac_ok_q;
		iface_n   = iface_q;
		rec       = '0;
		rec_valid = is_start || is_last;
		len18     = 18'(pos_n);
		ihl_j     = hn.vihl[3:0];
		uoff_j    = 18'd14 + 18'({ihl_j, 2'b00});
		bad = !active_q || len18 < 18'd42 || hn.ether_kind != ETHERTYPE_IPV4 ||
			hn.vihl[7:4] != 4'd4 || ihl_j < 4'd5 || uoff_j + 18'd8 > len18 ||
			hn.proto != PROTO_UDP || hn.dport != PORT_CLIENT || hn.sport != PORT_SERVER ||
			hn.ulen < 16'd248 || uoff_j + 18'd248 > len18 || hn.cookie != MAGIC_COOKIE;
		cur  = (hn.xid == cur_xid_q);
		prev = !cur && prev_xid_q != 32'd0 && hn.xid == prev_xid_q;
		phase_eff = prev ? PH_ACK : phase_q;
		server = (vn.server != 32'd0) ? vn.server : hn.src_ip;
		sane = !hn.src_mac[40] && hn.src_mac != 48'd0 && hn.src_mac != '1 &&
			hn.src_mac != own_mac_q;
		if (is_start) begin
			prev_xid_n = cur_xid_q;
			offered_n  = 32'd0;
			sserver_n  = 32'd0;
			smac_n     = 48'd0;
			smac_ok_n  = 1'b0;
			cur_xid_n  = cur_xid_q + XID_STEP;
			iface_n    = 32'd0;
			phase_n    = PH_OFFER;
			active_n   = 1'b1;
			rec.action = ACT_DISCOVER;
			rec.xid    = cur_xid_n;
		end else if (is_last && !bad) begin
			if (!cur && !prev) begin
				rec.action = ACT_MISMATCH;
				rec.xid    = cur_xid_q;
			end else begin
				if (prev) begin
					cur_xid_n = hn.xid;
					phase_n   = PH_ACK;
				end
				rec.xid = cur_xid_n;
				if (vn.msg == MSG_OFFER && phase_eff == PH_OFFER) begin
					offered_n   = hn.yiaddr;
					sserver_n   = server;
					smac_n      = hn.src_mac;
					smac_ok_n   = sane;
					phase_n     = PH_ACK;
					rec.action  = ACT_REQUEST;
					rec.client  = hn.yiaddr;
					rec.server  = server;
					rec.smac    = hn.src_mac;
					rec.smac_ok = sane;
				end else if (vn.msg == MSG_ACK && phase_eff == PH_ACK) begin
					rec.action  = ACT_LEASE;
					rec.client  = hn.yiaddr;
					rec.server  = server;
					rec.mask    = (vn.mask != 32'd0) ? vn.mask : MASK_DEFAULT;
					rec.router  = vn.router;
					rec.changed = (iface_q != hn.yiaddr);
					rec.smac    = smac_q;
					rec.smac_ok = smac_ok_q;
					rec.n = (cnt_n > DNS_CNT_W'(RESULT_CAP)) ? RES_CNT_W'(RESULT_CAP) :
						RES_CNT_W'(cnt_n);
					for (int k = 0; k < RESULT_CAP; k++) begin
						if (k < DNS_SLOTS) begin
							rec.dns[k] = dns_n[k];
						end
					end
					iface_n    = hn.yiaddr;
					phase_n    = PH_IDLE;
					active_n   = 1'b0;
					prev_xid_n = 32'd0;
					offered_n  = 32'd0;
					smac_ok_n  = 1'b0;
				end else begin
					rec.action = ACT_IGNORED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q  <= 48'd0;
			phase_q    <= PH_IDLE;
			active_q   <= 1'b0;
			cur_xid_q  <= XID_RESET;
			prev_xid_q <= 32'd0;
			offered_q  <= 32'd0;
			sserver_q  <= 32'd0;
			smac_q     <= 48'd0;
			smac_ok_q  <= 1'b0;
			iface_q    <= 32'd0;
			pos_q      <= '0;
			h_q        <= '0;
			o_q        <= '0;
			v_q        <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				own_mac_q <= cfg_data;
			end
			phase_q    <= phase_n;
			active_q   <= active_n;
			cur_xid_q  <= cur_xid_n;
			prev_xid_q <= prev_xid_n;
			offered_q  <= offered_n;
			sserver_q  <= sserver_n;
			smac_q     <= smac_n;
			smac_ok_q  <= smac_ok_n;
			iface_q    <= iface_n;
			if (is_start || is_last) begin
				pos_q <= '0;
				h_q   <= '0;
				o_q   <= '0;
				v_q   <= '0;
				cnt_q <= '0;
			end else begin
				pos_q <= pos_n;
				h_q   <= hn;
				o_q   <= on;
				v_q   <= vn;
				cnt_q <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DNS_SLOTS; j++) begin
			dns_q[j] <= dns_n[j];
		end
	end

endmodule

[src/dhcp_crp_queue.sv]
// Short record queue between the front and back parts.
module dhcp_crp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  dhcp_crp_pkg::rec_t wr_rec,
	output logic               q_full,
	output logic               q_empty,
	input  logic               rd_en,
	output dhcp_crp_pkg::rec_t rd_rec
);
	import dhcp_crp_pkg::*;

	localparam int DEPTH = 1 << QUEUE_PTR_W;

	rec_t                 mem_q [DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_W:0]   cnt_q;

	assign q_full  = (cnt_q == (QUEUE_PTR_W + 1)'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (QUEUE_PTR_W + 1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (QUEUE_PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

[src/dhcp_crp_back.sv]
// Back part: expands a decision record into one or more result words.
module dhcp_crp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  dhcp_crp_pkg::rec_t head,
	input  logic               pop,
	output logic               rd_en,
	output logic [2:0]         action,
	output logic [31:0]        transaction_id,
	output logic [31:0]        client_addr,
	output logic [31:0]        server_addr,
	output logic [31:0]        net_mask,
	output logic [31:0]        router_addr,
	output logic               addr_moved,
	output logic [47:0]        server_mac,
	output logic               server_mac_ok,
	output logic [31:0]        dns_server,
	output logic               last
);
	import dhcp_crp_pkg::*;

	localparam int K_W = $clog2(RESULT_CAP);

	logic [K_W-1:0] k_q;

	assign last = (head.n == '0) || (RES_CNT_W'(k_q) + RES_CNT_W'(1) == head.n);
	assign rd_en = pop && !q_empty && last;

	assign action         = head.action;
	assign transaction_id = head.xid;
	assign client_addr    = head.client;
	assign server_addr    = head.server;
	assign net_mask       = head.mask;
	assign router_addr    = head.router;
	assign addr_moved     = head.changed;
	assign server_mac     = head.smac;
	assign server_mac_ok  = head.smac_ok;
	assign dns_server     = (head.n == '0) ? 32'd0 : head.dns[k_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (pop && !q_empty) begin
			k_q <= last ? '0 : k_q + K_W'(1);
		end
	end

endmodule

[verif/dhcp_client_reply_parser_checker.sv]
// Checker that predicts and compares every result word of the DHCP client reply parser.
module dhcp_client_reply_parser_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  action,
	input  logic [31:0] transaction_id,
	input  logic [31:0] client_addr,
	input  logic [31:0] server_addr,
	input  logic [31:0] net_mask,
	input  logic [31:0] router_addr,
	input  logic        addr_moved,
	input  logic [47:0] server_mac,
	input  logic        server_mac_ok,
	input  logic [31:0] dns_server,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [47:0] cfg_data,
	output int          errors,
	output int          outstanding
);
	import dhcp_crp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  act;
		logic [31:0] xid;
		logic [31:0] client;
		logic [31:0] server;
		logic [31:0] mask;
		logic [31:0] router;
		logic        changed;
		logic [47:0] smac;
		logic        smac_ok;
		logic [31:0] dns;
		logic        last;
	} reply_t;

	reply_t replies_due[$];
	int error_count;

	logic [47:0] own_mac;
	phase_t      phase;
	logic        active;
	logic [31:0] cur_xid, prev_xid, offered, saved_server, iface;
	logic [47:0] saved_mac;
	logic        saved_ok;
	int          pos;

	logic [47:0] h_mac;
	logic [15:0] h_type, h_sport, h_dport, h_ulen;
	logic [7:0]  h_vihl, h_proto;
	logic [31:0] h_sip, h_xid, h_yi, h_cookie;

	opt_mode_t   o_mode;
	logic [7:0]  o_code;
	int          o_len, o_idx, o_pend;
	logic [31:0] o_word, o_first;
	logic [31:0] v_msg, v_server, v_mask, v_router;
	logic [31:0] dns_list[DNS_SLOTS_DEF];
	logic [31:0] dns_pend[DNS_SLOTS_DEF];
	int          dns_cnt;

	task automatic clear_frame();
		pos = 0;
		h_mac = '0; h_type = '0; h_sport = '0; h_dport = '0; h_ulen = '0;
		h_vihl = '0; h_proto = '0; h_sip = '0; h_xid = '0; h_yi = '0; h_cookie = '0;
		o_mode = OM_CODE; o_code = '0; o_len = 0; o_idx = 0; o_pend = 0;
		o_word = '0; o_first = '0;
		v_msg = '0; v_server = '0; v_mask = '0; v_router = '0;
		dns_cnt = 0;
		for (int i = 0; i < DNS_SLOTS_DEF; i++) begin
			dns_list[i] = '0;
			dns_pend[i] = '0;
		end
	endtask

	task automatic option_byte(input int r, input logic [7:0] b);
		case (o_mode)
			OM_CODE: begin
				if (r + 1 >= int'(h_ulen) || b == OPT_END) begin
					o_mode = OM_DONE;
				end else if (b != OPT_PAD) begin
					o_code = b;
					o_mode = OM_LEN;
				end
			end
			OM_LEN: begin
				if (r + 1 + int'(b) > int'(h_ulen)) begin
					o_mode = OM_DONE;
				end else begin
					o_len = int'(b); o_idx = 0; o_word = '0; o_first = '0; o_pend = 0;
					o_mode = (b == 8'd0) ? OM_CODE : OM_BODY;
				end
			end
			OM_BODY: begin
				o_word = {o_word[23:0], b};
				if (o_code == OPT_MSG && o_idx == 0) o_first = {24'd0, b};
				if (o_code != OPT_MSG && o_idx == 3) o_first = o_word;
				if (o_code == OPT_DNS && o_idx % 4 == 3 && o_word != 0 &&
					dns_cnt + o_pend < DNS_SLOTS_DEF) begin
					dns_pend[o_pend] = o_word;
					o_pend++;
				end
				o_idx++;
				if (o_idx >= o_len) begin
					if (o_code == OPT_MSG) v_msg = o_first;
					else if (o_len >= 4) begin
						if (o_code == OPT_SERVER) v_server = o_first;
						else if (o_code == OPT_MASK) v_mask = o_first;
						else if (o_code == OPT_ROUTER) v_router = o_first;
					end
					if (o_code == OPT_DNS) begin
						for (int i = 0; i < o_pend && dns_cnt < DNS_SLOTS_DEF; i++) begin
							dns_list[dns_cnt] = dns_pend[i];
							dns_cnt++;
						end
					end
					o_mode = OM_CODE;
				end
			end
			default: ;
		endcase
	endtask

	task automatic header_byte(input int p, input logic [7:0] b);
		int ihl, uoff, r;
		if (p >= 6 && p < 12) h_mac = {h_mac[39:0], b};
		if (p == 12 || p == 13) h_type = {h_type[7:0], b};
		if (p == 14) h_vihl = b;
		if (p == 23) h_proto = b;
		if (p >= 26 && p < 30) h_sip = {h_sip[23:0], b};
		ihl = int'(h_vihl[3:0]);
		uoff = 14 + 4 * ihl;
		if (p >= 15 && h_vihl[7:4] == 4'd4 && ihl >= 5 && p >= uoff) begin
			r = p - uoff;
			if (r < 2) h_sport = {h_sport[7:0], b};
			else if (r < 4) h_dport = {h_dport[7:0], b};
			else if (r < 6) h_ulen = {h_ulen[7:0], b};
			else if (r >= 12 && r < 16) h_xid = {h_xid[23:0], b};
			else if (r >= 24 && r < 28) h_yi = {h_yi[23:0], b};
			else if (r >= 244 && r < 248) h_cookie = {h_cookie[23:0], b};
			else if (r >= 248 && h_ulen >= 16'd248) option_byte(r, b);
		end
	endtask

	function automatic logic mac_usable(input logic [47:0] m);
		return !m[40] && m != '0 && m != '1 && m != own_mac;
	endfunction

	task automatic judge_frame();
		int ihl, uoff, n;
		logic hit_cur, hit_prev;
		logic [31:0] server;
		reply_t rep;
		ihl = int'(h_vihl[3:0]);
		uoff = 14 + 4 * ihl;
		rep = '0;
		rep.last = 1'b1;
		if (!active || pos < 42 || h_type != ETHERTYPE_IPV4 || h_vihl[7:4] != 4'd4 ||
			ihl < 5 || uoff + 8 > pos || h_proto != PROTO_UDP || h_dport != PORT_CLIENT ||
			h_sport != PORT_SERVER || h_ulen < 16'd248 || uoff + 248 > pos ||
			h_cookie != MAGIC_COOKIE) begin
			rep.act = ACT_DROP;
			replies_due.push_back(rep);
			return;
		end
		hit_cur = (h_xid == cur_xid);
		hit_prev = !hit_cur && prev_xid != 0 && h_xid == prev_xid;
		if (!hit_cur && !hit_prev) begin
			rep.act = ACT_MISMATCH;
			rep.xid = cur_xid;
			replies_due.push_back(rep);
			return;
		end
		if (hit_prev) begin
			cur_xid = h_xid;
			phase = PH_ACK;
		end
		server = (v_server != 0) ? v_server : h_sip;
		rep.xid = cur_xid;
		if (v_msg == MSG_OFFER && phase == PH_OFFER) begin
			offered = h_yi;
			saved_server = server;
			saved_mac = h_mac;
			saved_ok = mac_usable(h_mac);
			phase = PH_ACK;
			rep.act = ACT_REQUEST;
			rep.client = offered;
			rep.server = saved_server;
			rep.smac = saved_mac;
			rep.smac_ok = saved_ok;
			replies_due.push_back(rep);
		end else if (v_msg == MSG_ACK && phase == PH_ACK) begin
			rep.act = ACT_LEASE;
			rep.client = h_yi;
			rep.server = server;
			rep.mask = (v_mask != 0) ? v_mask : MASK_DEFAULT;
			rep.router = v_router;
			rep.changed = (iface != h_yi);
			rep.smac = saved_mac;
			rep.smac_ok = saved_ok;
			iface = h_yi;
			phase = PH_IDLE;
			active = 1'b0;
			prev_xid = '0;
			offered = '0;
			saved_ok = 1'b0;
			n = (dns_cnt > RESULT_CAP) ? RESULT_CAP : dns_cnt;
			if (n == 0) begin
				replies_due.push_back(rep);
			end else begin
				for (int k = 0; k < n; k++) begin
					rep.dns = dns_list[k];
					rep.last = (k + 1 == n);
					replies_due.push_back(rep);
				end
			end
		end else begin
			rep.act = ACT_IGNORED;
			replies_due.push_back(rep);
		end
	endtask

	task automatic absorb_word(input logic op, input logic [7:0] b, input logic lb);
		reply_t rep;
		if (op) begin
			prev_xid = cur_xid;
			offered = '0;
			saved_server = '0;
			saved_mac = '0;
			saved_ok = 1'b0;
			cur_xid = cur_xid + XID_STEP;
			iface = '0;
			phase = PH_OFFER;
			active = 1'b1;
			clear_frame();
			rep = '0;
			rep.act = ACT_DISCOVER;
			rep.xid = cur_xid;
			rep.last = 1'b1;
			replies_due.push_back(rep);
		end else begin
			if (pos < MAX_FRAME_BYTES_DEF) begin
				header_byte(pos, b);
				pos++;
			end
			if (lb) begin
				judge_frame();
				clear_frame();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t got, want;
		if (!arst_n) begin
			own_mac = '0;
			phase = PH_IDLE;
			active = 1'b0;
			cur_xid = XID_RESET;
			prev_xid = '0;
			offered = '0;
			saved_server = '0;
			saved_mac = '0;
			saved_ok = 1'b0;
			iface = '0;
			clear_frame();
			replies_due.delete();
			error_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) own_mac = cfg_data;
			if (pop && !empty) begin
				got = {action, transaction_id, client_addr, server_addr, net_mask,
					router_addr, addr_moved, server_mac, server_mac_ok, dns_server, last};
				if (replies_due.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%t unexpected result word: act %0d xid %h", $realtime,
							got.act, got.xid);
				end else begin
					want = replies_due.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%t result word mismatch", $realtime);
							$display("  expected act %0d xid %h cl %h sv %h mk %h rt %h ch %b",
								want.act, want.xid, want.client, want.server, want.mask,
								want.router, want.changed);
							$display("           mac %h ok %b dns %h last %b",
								want.smac, want.smac_ok, want.dns, want.last);
							$display("  actual   act %0d xid %h cl %h sv %h mk %h rt %h ch %b",
								got.act, got.xid, got.client, got.server, got.mask,
								got.router, got.changed);
							$display("           mac %h ok %b dns %h last %b",
								got.smac, got.smac_ok, got.dns, got.last);
						end
					end
				end
			end
			if (push && !full) absorb_word(operation, data_byte, last_byte);
		end
		errors <= error_count;
		outstanding <= replies_due.size();
	end

endmodule

[verif/dhcp_client_reply_parser_test.sv]
// Stimulus and verdict for the DHCP client reply parser.
module dhcp_client_reply_parser_test;
	import dhcp_crp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;

	typedef enum int {
		FL_NONE, FL_ETYPE, FL_PROTO, FL_PORT, FL_COOKIE, FL_ULEN, FL_SHORTULEN,
		FL_TRUNC, FL_IHL6, FL_BADIHL, FL_LONG
	} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        operation = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  action;
	logic [31:0] transaction_id, client_addr, server_addr, net_mask, router_addr;
	logic        addr_moved, server_mac_ok, last;
	logic [47:0] server_mac;
	logic [31:0] dns_server;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [47:0] cfg_data = '0;
	int          errors, outstanding;
	int          idle_cycles = 0;
	logic        steady = 1'b0;

	logic [7:0]  frame_bytes[$];
	logic [31:0] xid_now = XID_RESET;
	logic [31:0] xid_old = '0;
	logic [47:0] mac_setting = '0;

	dhcp_client_reply_parser dut (.*);
	dhcp_client_reply_parser_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("** dhcp_client_reply_parser: FAILED **");
					$finish;
				end
			end
		end
	end

	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	task automatic send_word(input logic op, input logic [7:0] b, input logic lb);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		data_byte <= b;
		last_byte <= lb;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_start();
		send_word(1'b1, 8'($urandom), 1'($urandom));
		xid_old = xid_now;
		xid_now = xid_now + XID_STEP;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_word(1'b0, frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mac(input logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mac_setting = value;
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [47:0] pick_mac();
		logic [47:0] m;
		m = 48'({$urandom, $urandom});
		case ($urandom_range(0, 7))
			0: m = mac_setting;
			1: m = '0;
			2: m = '1;
			3: m[40] = 1'b1;
			default: m[40] = 1'b0;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] pick_xid();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return $urandom;
		if (k == 1) return xid_old;
		return xid_now;
	endfunction

	task automatic push_word(inout logic [7:0] q[$], input logic [31:0] w);
		for (int i = 3; i >= 0; i--) q.push_back(w[8*i +: 8]);
	endtask

	task automatic build_frame(input logic [31:0] xid, input logic [7:0] msg,
		input logic [47:0] smac, input int ndns, input flaw_t flaw);
		logic [7:0] opts[$];
		logic [31:0] yi;
		int ulen, ihl, cut;
		frame_bytes.delete();
		if ($urandom_range(0, 3) == 0) opts.push_back(OPT_PAD);
		opts.push_back(OPT_MSG); opts.push_back(8'd1); opts.push_back(msg);
		if ($urandom_range(0, 1)) begin
			opts.push_back(OPT_SERVER); opts.push_back(8'd4); push_word(opts, $urandom);
		end
		if ($urandom_range(0, 1)) begin
			opts.push_back(OPT_MASK); opts.push_back(8'd4); push_word(opts, $urandom);
		end
		if ($urandom_range(0, 1)) begin
			opts.push_back(OPT_ROUTER);
			if ($urandom_range(0, 3) == 0) begin
				opts.push_back(8'd8); push_word(opts, $urandom); push_word(opts, $urandom);
			end else begin
				opts.push_back(8'd4); push_word(opts, $urandom);
			end
		end
		if (ndns > 0) begin
			opts.push_back(OPT_DNS); opts.push_back(8'(4 * ndns));
			for (int i = 0; i < ndns; i++)
				push_word(opts, ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom);
		end
		if ($urandom_range(0, 3) == 0) begin
			opts.push_back(8'($urandom)); opts.push_back(8'd2);
			opts.push_back(8'($urandom)); opts.push_back(8'($urandom));
		end
		if ($urandom_range(0, 1)) begin
			opts.push_back(OPT_MSG); opts.push_back(8'd0);
		end
		opts.push_back(OPT_END);
		repeat ($urandom_range(0, 3)) opts.push_back(8'($urandom));

		ulen = 248 + opts.size();
		if (flaw == FL_ULEN) ulen = 248 + $urandom_range(0, opts.size());
		if (flaw == FL_SHORTULEN) ulen = $urandom_range(0, 247);
		ihl = (flaw == FL_IHL6) ? 6 : (flaw == FL_BADIHL) ? $urandom_range(0, 4) : 5;
		yi = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;

		repeat (6) frame_bytes.push_back(8'($urandom));
		for (int i = 5; i >= 0; i--) frame_bytes.push_back(smac[8*i +: 8]);
		if (flaw == FL_ETYPE) begin
			frame_bytes.push_back(8'h86); frame_bytes.push_back(8'hdd);
		end else begin
			frame_bytes.push_back(ETHERTYPE_IPV4[15:8]);
			frame_bytes.push_back(ETHERTYPE_IPV4[7:0]);
		end
		frame_bytes.push_back({4'h4, 4'(ihl)});
		repeat (8) frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back((flaw == FL_PROTO) ? 8'd6 : PROTO_UDP);
		repeat (10) frame_bytes.push_back(8'($urandom));
		if (ihl == 6) repeat (4) frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back((flaw == FL_PORT) ? 8'd68 : PORT_SERVER[7:0]);
		frame_bytes.push_back(8'h00); frame_bytes.push_back(PORT_CLIENT[7:0]);
		frame_bytes.push_back(8'(ulen >> 8)); frame_bytes.push_back(8'(ulen));
		repeat (2) frame_bytes.push_back(8'($urandom));
		for (int k = 0; k < 236; k++) begin
			if (k >= 4 && k < 8) frame_bytes.push_back(xid[8*(7-k) +: 8]);
			else if (k >= 16 && k < 20) frame_bytes.push_back(yi[8*(19-k) +: 8]);
			else frame_bytes.push_back(8'($urandom));
		end
		push_word(frame_bytes, (flaw == FL_COOKIE) ? MAGIC_COOKIE ^ 32'h100 : MAGIC_COOKIE);
		foreach (opts[i]) frame_bytes.push_back(opts[i]);
		if (flaw == FL_TRUNC) begin
			cut = $urandom_range(1, frame_bytes.size() - 1);
			while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
		end
		if (flaw == FL_LONG) while (frame_bytes.size() < 2100) frame_bytes.push_back(8'($urandom));
	endtask

	task automatic noise_frame(input int lo, input int hi);
		frame_bytes.delete();
		repeat ($urandom_range(lo, hi)) frame_bytes.push_back(8'($urandom));
		send_frame();
	endtask

	task automatic offer_frame(input logic [31:0] xid, input flaw_t flaw);
		build_frame(xid, MSG_OFFER[7:0], pick_mac(), $urandom_range(0, 2), flaw);
		send_frame();
		if (xid == xid_old && xid != xid_now && xid_old != 0) xid_now = xid_old;
	endtask

	task automatic ack_frame(input logic [31:0] xid, input logic [7:0] msg, input flaw_t flaw);
		build_frame(xid, msg, pick_mac(), $urandom_range(0, 6), flaw);
		send_frame();
		if (xid == xid_old && xid != xid_now && xid_old != 0) xid_now = xid_old;
		if (msg == MSG_ACK[7:0] && flaw == FL_NONE) xid_old = '0;
	endtask

	initial begin
		flaw_t flaw;
		int k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mac(48'({$urandom, $urandom}) & 48'hFEFF_FFFF_FFFF);

		steady = 1'b1;
		offer_frame(xid_now, FL_NONE);
		send_start();
		send_start();
		noise_frame(10, 30);
		offer_frame($urandom, FL_NONE);
		offer_frame(xid_now, FL_ETYPE);
		offer_frame(xid_now, FL_COOKIE);
		offer_frame(xid_now, FL_SHORTULEN);
		steady = 1'b0;
		build_frame(xid_now, MSG_OFFER[7:0], mac_setting, 0, FL_NONE);
		send_frame();
		build_frame(xid_now, MSG_ACK[7:0], pick_mac(), 6, FL_NONE);
		send_frame();
		xid_old = '0;
		ack_frame(xid_now, MSG_ACK[7:0], FL_NONE);
		send_start();
		build_frame(xid_now, MSG_OFFER[7:0], pick_mac(), 1, FL_NONE);
		for (int i = 0; i < 100; i++) send_word(1'b0, frame_bytes[i], 1'b0);
		send_start();
		ack_frame(xid_old, MSG_ACK[7:0], FL_ULEN);
		send_start();
		offer_frame(xid_now, FL_LONG);
		ack_frame(xid_now, 8'd3, FL_IHL6);
		ack_frame(xid_now, MSG_ACK[7:0], FL_IHL6);
		drain();
		write_mac('1);

		for (int s = 0; s < 36; s++) begin
			if (s == 12) begin
				drain();
				write_mac('0);
			end
			if (s == 24) begin
				drain();
				write_mac(48'({$urandom, $urandom}));
			end
			steady = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 9);
			send_start();
			if (k == 0) noise_frame(30, 400);
			flaw = ($urandom_range(0, 4) == 0) ? flaw_t'($urandom_range(1, 9)) : FL_NONE;
			offer_frame(pick_xid(), flaw);
			if (k == 1) offer_frame(pick_xid(), FL_NONE);
			if (k == 2) begin
				build_frame(xid_now, MSG_OFFER[7:0], pick_mac(), 1, FL_NONE);
				for (int i = 0; i < 60; i++) send_word(1'b0, frame_bytes[i], 1'b0);
				continue;
			end
			flaw = ($urandom_range(0, 4) == 0) ? flaw_t'($urandom_range(1, 9)) : FL_NONE;
			ack_frame(pick_xid(), ($urandom_range(0, 5) == 0) ? 8'($urandom) : MSG_ACK[7:0],
				flaw);
		end
		steady = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("** dhcp_client_reply_parser: PASSED **");
		end else begin
			$display("** dhcp_client_reply_parser: FAILED **");
		end
		$finish;
	end

endmodule

[filelist.f]
src/dhcp_crp_pkg.sv
src/dhcp_crp_front.sv
src/dhcp_crp_queue.sv
src/dhcp_crp_back.sv
src/dhcp_client_reply_parser.sv
verif/dhcp_client_reply_parser_checker.sv
verif/dhcp_client_reply_parser_test.sv
